// ----- sv/lfsa_pkg.sv -----
// Shared types and constants for the lowest-free-slot interval allocator.
package lfsa_pkg;

    localparam int TIME_W = 16;
    localparam int TGT_W  = 6;

    // Classification that the front end attaches to each beat.
    typedef struct packed {
        logic wr;    // the beat is stored as a guest
        logic last;  // the beat closes the set
        logic ovf;   // some beat of this set was dropped
    } lfsa_cls_t;

endpackage

// ----- sv/lfsa_front.sv -----
// Front end: counts guests of the current set and classifies each beat.
module lfsa_front import lfsa_pkg::*; #(
    parameter int MAX_GUESTS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic                              last_item,
    output lfsa_cls_t                         cls,
    output logic [$clog2(MAX_GUESTS)-1:0]     idx,
    output logic [$clog2(MAX_GUESTS+1)-1:0]   count
);
    localparam int IDX_W = $clog2(MAX_GUESTS);
    localparam int CNT_W = $clog2(MAX_GUESTS + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             ovf_reg;
    logic             room;

    assign room     = cnt_reg < CNT_W'(MAX_GUESTS);
    assign cls.wr   = room;
    assign cls.last = last_item;
    assign cls.ovf  = ovf_reg | ~room;
    assign idx      = cnt_reg[IDX_W-1:0];
    assign count    = room ? cnt_reg + CNT_W'(1) : cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last_item)
            begin
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= count;
                ovf_reg <= cls.ovf;
            end
        end
    end

endmodule

// ----- sv/lfsa_fifo.sv -----
// Two-entry queue between the front end and the replay engine.
module lfsa_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         empty
);
    logic [W-1:0] mem_reg [2];
    logic         wp_reg;
    logic         rp_reg;
    logic [1:0]   cnt_reg;
    logic         do_push;
    logic         do_pop;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
                wp_reg <= ~wp_reg;
            if (do_pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ----- sv/lfsa_back.sv -----
// Replay engine: stores guests, replays arrivals and holds the result register.
module lfsa_back import lfsa_pkg::*; #(
    parameter int MAX_GUESTS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    output logic                             q_pop,
    input  lfsa_cls_t                        q_cls,
    input  logic [$clog2(MAX_GUESTS)-1:0]    q_idx,
    input  logic [$clog2(MAX_GUESTS+1)-1:0]  q_count,
    input  logic [TIME_W-1:0]                q_arrive,
    input  logic [TIME_W-1:0]                q_leave,
    input  logic [TGT_W-1:0]                 target,
    output logic                             res_valid,
    input  logic                             res_pop,
    output logic [5:0]                       res_slot,
    output logic                             res_found,
    output logic                             res_overflow
);
    localparam int IDX_W = $clog2(MAX_GUESTS);
    localparam int CNT_W = $clog2(MAX_GUESTS + 1);
    localparam int CMP_W = (CNT_W > TGT_W) ? CNT_W : TGT_W;
    localparam int SW    = (IDX_W > 6) ? IDX_W : 6;

    typedef enum logic [2:0] {S_IDLE, S_FIND, S_REL, S_ALLOC, S_DONE} state_t;

    logic [TIME_W-1:0] arr_mem [MAX_GUESTS];
    logic [TIME_W-1:0] lev_mem [MAX_GUESTS];
    logic [IDX_W-1:0]  slt_mem [MAX_GUESTS];
    logic [TIME_W-1:0] a_q;
    logic [TIME_W-1:0] l_q;
    logic [IDX_W-1:0]  s_q;

    state_t            state_reg;
    logic [CNT_W-1:0]  sc_reg;
    logic              vd_reg;
    logic [IDX_W-1:0]  id_reg;
    logic              first_reg;
    logic [TIME_W-1:0] la_reg;
    logic [IDX_W-1:0]  lg_reg;
    logic [TIME_W-1:0] ca_reg;
    logic [IDX_W-1:0]  cg_reg;
    logic              have_reg;
    logic [TIME_W-1:0] ba_reg;
    logic [IDX_W-1:0]  bg_reg;
    logic [IDX_W-1:0]  ss_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              ovf_reg;
    logic [MAX_GUESTS-1:0] free_reg;
    logic              pf_reg;
    logic [IDX_W-1:0]  ps_reg;
    logic              rv_reg;
    logic [5:0]        rs_reg;
    logic              rf_reg;
    logic              ro_reg;

    logic              load;
    logic              issue;
    logic              scan_done;
    logic              is_cand;
    logic              is_rel;
    logic              tgt_ok;
    logic              is_tgt;
    logic [SW-1:0]     ps_wide;

    function automatic logic key_gt(input logic [TIME_W-1:0] a, input logic [IDX_W-1:0] i,
                                    input logic [TIME_W-1:0] b, input logic [IDX_W-1:0] j);
        key_gt = (a > b) || ((a == b) && (i > j));
    endfunction

    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign load      = q_pop;
    assign issue     = sc_reg < cnt_reg;
    assign scan_done = !issue && !vd_reg;
    assign tgt_ok    = CMP_W'(target) < CMP_W'(q_count);
    assign is_tgt    = CMP_W'(cg_reg) == CMP_W'(target);
    assign ps_wide   = SW'(ps_reg);

    // A candidate for the next arrival lies strictly after the last one served.
    assign is_cand = vd_reg && (first_reg || key_gt(a_q, id_reg, la_reg, lg_reg))
                     && (!have_reg || key_gt(ba_reg, bg_reg, a_q, id_reg));

    // Release a seated guest once: when its leave time is reached and it was not
    // already due at the previous arrival.
    assign is_rel = vd_reg && !first_reg && !key_gt(a_q, id_reg, la_reg, lg_reg)
                    && (l_q <= ca_reg)
                    && !(key_gt(la_reg, lg_reg, a_q, id_reg) && (l_q <= la_reg));

    always_ff @(posedge clk)
    begin
        if (load && q_cls.wr)
        begin
            arr_mem[q_idx] <= q_arrive;
            lev_mem[q_idx] <= q_leave;
        end
        if (state_reg == S_ALLOC && free_reg[ss_reg])
            slt_mem[cg_reg] <= ss_reg;
        a_q <= arr_mem[sc_reg[IDX_W-1:0]];
        l_q <= lev_mem[sc_reg[IDX_W-1:0]];
        s_q <= slt_mem[sc_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sc_reg    <= '0;
            vd_reg    <= 1'b0;
            id_reg    <= '0;
            first_reg <= 1'b1;
            la_reg    <= '0;
            lg_reg    <= '0;
            ca_reg    <= '0;
            cg_reg    <= '0;
            have_reg  <= 1'b0;
            ba_reg    <= '0;
            bg_reg    <= '0;
            ss_reg    <= '0;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            free_reg  <= '1;
            pf_reg    <= 1'b0;
            ps_reg    <= '0;
            rv_reg    <= 1'b0;
            rs_reg    <= '0;
            rf_reg    <= 1'b0;
            ro_reg    <= 1'b0;
        end
        else
        begin
            if (rv_reg && res_pop)
                rv_reg <= 1'b0;
            unique case (state_reg) inside
                S_IDLE:
                begin
                    if (load && q_cls.last)
                    begin
                        cnt_reg   <= q_count;
                        ovf_reg   <= q_cls.ovf;
                        free_reg  <= '1;
                        first_reg <= 1'b1;
                        have_reg  <= 1'b0;
                        sc_reg    <= '0;
                        vd_reg    <= 1'b0;
                        pf_reg    <= 1'b0;
                        ps_reg    <= '0;
                        state_reg <= tgt_ok ? S_FIND : S_DONE;
                    end
                end
                S_FIND, S_REL:
                begin
                    vd_reg <= issue;
                    id_reg <= sc_reg[IDX_W-1:0];
                    if (issue)
                        sc_reg <= sc_reg + CNT_W'(1);
                    if (state_reg == S_FIND && is_cand)
                    begin
                        have_reg <= 1'b1;
                        ba_reg   <= a_q;
                        bg_reg   <= id_reg;
                    end
                    if (state_reg == S_REL && is_rel)
                        free_reg[s_q] <= 1'b1;
                    if (scan_done)
                    begin
                        sc_reg <= '0;
                        ss_reg <= '0;
                        if (state_reg == S_FIND)
                        begin
                            ca_reg    <= ba_reg;
                            cg_reg    <= bg_reg;
                            state_reg <= S_REL;
                        end
                        else
                            state_reg <= S_ALLOC;
                    end
                end
                S_ALLOC:
                begin
                    if (free_reg[ss_reg])
                    begin
                        free_reg[ss_reg] <= 1'b0;
                        la_reg    <= ca_reg;
                        lg_reg    <= cg_reg;
                        first_reg <= 1'b0;
                        have_reg  <= 1'b0;
                        if (is_tgt)
                        begin
                            pf_reg    <= 1'b1;
                            ps_reg    <= ss_reg;
                            state_reg <= S_DONE;
                        end
                        else
                            state_reg <= S_FIND;
                    end
                    else
                        ss_reg <= ss_reg + IDX_W'(1);
                end
                S_DONE:
                begin
                    if (!rv_reg)
                    begin
                        rv_reg    <= 1'b1;
                        rs_reg    <= ps_wide[5:0];
                        rf_reg    <= pf_reg;
                        ro_reg    <= ovf_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign res_valid    = rv_reg;
    assign res_slot     = rs_reg;
    assign res_found    = rf_reg;
    assign res_overflow = ro_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && rv_reg && !res_pop) |=> rv_reg && $stable(rs_reg))
        else $error("result register changed while a beat was waiting");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sc_reg <= cnt_reg)
        else $error("scan counter ran past the guest count");
    a_alloc_has_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC) |-> (free_reg != '0))
        else $error("allocation with no free slot");
    a_find_has_best: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND && scan_done) |-> have_reg)
        else $error("arrival scan found no guest");
`endif

endmodule

// ----- sv/lowest_free_slot_interval_allocator.sv -----
// Loading takes one beat per cycle while full is low; the two-entry queue lets loading run while a result waits.
// During a replay the queue takes two more beats, then full stays high until the replay ends.
// The closing beat starts a replay that runs, per arrival, two scans of the guest
// store plus a search for the lowest free slot.
// Reset clears all control state and the free map; stores need no clearing pass.
module lowest_free_slot_interval_allocator import lfsa_pkg::*; #(
    parameter int MAX_GUESTS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [TIME_W-1:0] arrive_time,
    input  logic [TIME_W-1:0] leave_time,
    input  logic              last_item,
    output logic              empty,
    input  logic              pop,
    output logic [5:0]        slot,
    output logic              found,
    output logic              overflow,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TGT_W-1:0]  cfg_data
);
    localparam int IDX_W = $clog2(MAX_GUESTS);
    localparam int CNT_W = $clog2(MAX_GUESTS + 1);
    localparam int QW    = 3 + IDX_W + CNT_W + 2 * TIME_W;

    logic [TGT_W-1:0]  target_reg;
    logic              accept;
    lfsa_cls_t         f_cls;
    logic [IDX_W-1:0]  f_idx;
    logic [CNT_W-1:0]  f_count;
    logic [QW-1:0]     q_wdata;
    logic [QW-1:0]     q_rdata;
    logic              q_empty;
    logic              q_pop;
    lfsa_cls_t         b_cls;
    logic [IDX_W-1:0]  b_idx;
    logic [CNT_W-1:0]  b_count;
    logic [TIME_W-1:0] b_arrive;
    logic [TIME_W-1:0] b_leave;
    logic              res_valid;

    assign cfg_ready = 1'b1;
    assign accept    = push & ~full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_reg <= '0;
        else if (cfg_valid)
            target_reg <= cfg_data;
    end

    lfsa_front #(.MAX_GUESTS(MAX_GUESTS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .last_item (last_item),
        .cls       (f_cls),
        .idx       (f_idx),
        .count     (f_count)
    );

    assign q_wdata = {f_cls, f_idx, f_count, arrive_time, leave_time};

    lfsa_fifo #(.W(QW)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_wdata),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign {b_cls, b_idx, b_count, b_arrive, b_leave} = q_rdata;

    lfsa_back #(.MAX_GUESTS(MAX_GUESTS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_cls        (b_cls),
        .q_idx        (b_idx),
        .q_count      (b_count),
        .q_arrive     (b_arrive),
        .q_leave      (b_leave),
        .target       (target_reg),
        .res_valid    (res_valid),
        .res_pop      (pop),
        .res_slot     (slot),
        .res_found    (found),
        .res_overflow (overflow)
    );

    assign empty = ~res_valid;

endmodule
